// ===== src/pgw_pkg.sv =====
// Package for the four-level page walker: field widths, entry bit positions,
// status and page-size codes, and the virtual-address slot selector.
// No dependencies.
package pgw_pkg;

	localparam int DEF_FRAMES        = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int SLOT_W            = 9;
	localparam int ROOT_W            = 4;
	localparam int IDX_W             = 13;
	localparam int ENTRY_W           = 64;
	localparam int VA_W              = 48;
	localparam int PA_W              = 52;
	localparam int STATUS_W          = 2;
	localparam int SIZE_W            = 2;
	localparam int PAGE_SHIFT        = 12;

	// entry layout
	localparam int PTE_P  = 0;
	localparam int PTE_US = 2;
	localparam int PTE_PS = 7;

	// item operations
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	// walk levels: top table down to leaf table
	localparam logic [1:0] LVL_TOP  = 2'd3;
	localparam logic [1:0] LVL_1G   = 2'd2;
	localparam logic [1:0] LVL_2M   = 2'd1;
	localparam logic [1:0] LVL_LEAF = 2'd0;

	typedef enum logic [STATUS_W-1:0] {
		ST_MAPPED      = 2'd0,
		ST_NOT_PRESENT = 2'd1,
		ST_OUTSIDE     = 2'd2
	} status_t;

	typedef enum logic [SIZE_W-1:0] {
		PG_4K = 2'd0,
		PG_2M = 2'd1,
		PG_1G = 2'd2
	} size_t;

	// controller to datapath
	typedef struct packed {
		logic       clear_step;
		logic       wr_item;
		logic       start;
		logic       walk_next;
		logic       load_out;
		logic [1:0] level;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic done;
	} dp_stat_t;

	// nine-bit table slot of a virtual address at a given level
	function automatic logic [SLOT_W-1:0] slot_of(input logic [VA_W-1:0] va,
			input logic [1:0] lvl);
		logic [SLOT_W-1:0] s;
		case (lvl)
			LVL_TOP:  s = va[47:39];
			LVL_1G:   s = va[38:30];
			LVL_2M:   s = va[29:21];
			default:  s = va[20:12];
		endcase
		return s;
	endfunction

endpackage

// ===== src/pgw_ifs.sv =====
// Request and response channel interfaces of the page walker.
// Depends on pgw_pkg.
interface pgw_req_if import pgw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [IDX_W-1:0]   entry_index;
	logic [ENTRY_W-1:0] entry_value;
	logic [VA_W-1:0]    virt_addr;

	modport source (output valid, operation, entry_index, entry_value, virt_addr,
		input ready);
	modport sink (input valid, operation, entry_index, entry_value, virt_addr,
		output ready);
endinterface

interface pgw_rsp_if import pgw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PA_W-1:0]     phys_addr;
	logic [SIZE_W-1:0]   pg_size;
	logic                user_ok;

	modport source (output valid, status, phys_addr, pg_size, user_ok,
		input ready);
	modport sink (input valid, status, phys_addr, pg_size, user_ok,
		output ready);
endinterface

// ===== src/pgw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/pgw_datapath.sv =====
// Page walker datapath: table store, clear counter, root register, walk
// registers, level evaluation and the result register.
// Depends on pgw_pkg and pgw_ram.
module pgw_datapath import pgw_pkg::*; #(
	parameter int FRAMES = DEF_FRAMES,
	localparam int DEPTH = FRAMES * ENTRIES_PER_TABLE,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ROOT_W-1:0]   cfg_wdata,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [ENTRY_W-1:0]  entry_value,
	input  logic [VA_W-1:0]     virt_addr,
	output logic [STATUS_W-1:0] status,
	output logic [PA_W-1:0]     phys_addr,
	output logic [SIZE_W-1:0]   pg_size,
	output logic                user_ok
);

	localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FULL_AW = FRAME_W + SLOT_W;
	localparam int NFR_W   = PA_W - PAGE_SHIFT;

	logic [ROOT_W-1:0]  root_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [VA_W-1:0]    va_q;
	logic               bad_q;
	logic               user_q;

	logic [ENTRY_W-1:0] rd;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [FULL_AW-1:0] raddr_full;
	logic [31:0]        idx_ext;
	logic [31:0]        root_ext;
	logic               root_bad;
	logic               wr_ok;
	logic [NFR_W-1:0]   next_fr;
	logic               next_bad;
	logic               user_acc;

	status_t            res_st;
	size_t              res_sz;
	logic [PA_W-1:0]    res_pa;
	logic               res_user;
	logic               res_done;

	// root register and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				root_q <= cfg_wdata;
			end
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	assign stat.clear_last = (clr_cnt_q == AW'(DEPTH - 1));

	// range checks
	assign idx_ext  = 32'(entry_index);
	assign root_ext = 32'(root_q);
	assign wr_ok    = idx_ext < 32'(DEPTH);
	assign root_bad = root_ext >= 32'(FRAMES);
	assign next_fr  = rd[PA_W-1:PAGE_SHIFT];
	assign next_bad = next_fr >= NFR_W'(FRAMES);

	// store ports: the clear sweep owns the write port after reset
	assign ram_we    = cmd.clear_step | (cmd.wr_item & wr_ok);
	assign ram_waddr = cmd.clear_step ? clr_cnt_q : idx_ext[AW-1:0];
	assign ram_wdata = cmd.clear_step ? '0 : entry_value;

	// first lookup from the root, later ones from the entry just read
	assign raddr_full = cmd.start
		? {root_ext[FRAME_W-1:0], slot_of(virt_addr, LVL_TOP)}
		: {rd[PAGE_SHIFT +: FRAME_W], slot_of(va_q, cmd.level - 2'd1)};
	assign ram_raddr = raddr_full[AW-1:0];
	assign ram_re    = (cmd.start & ~root_bad) | cmd.walk_next;

	pgw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	// evaluate the entry read at the current level
	assign user_acc = user_q & rd[PTE_US];

	always_comb begin
		res_done = 1'b1;
		res_st   = ST_NOT_PRESENT;
		res_sz   = PG_4K;
		res_pa   = '0;
		res_user = 1'b0;
		if (bad_q) begin
			res_st = ST_OUTSIDE;
		end else if (!rd[PTE_P]) begin
			res_st = ST_NOT_PRESENT;
		end else if (cmd.level == LVL_LEAF) begin
			res_st   = ST_MAPPED;
			res_pa   = {rd[PA_W-1:12], va_q[11:0]};
			res_user = user_acc;
		end else if (rd[PTE_PS]) begin
			// huge bit at the top level is not a valid mapping
			if (cmd.level == LVL_1G) begin
				res_st   = ST_MAPPED;
				res_sz   = PG_1G;
				res_pa   = {rd[PA_W-1:30], va_q[29:0]};
				res_user = user_acc;
			end else if (cmd.level == LVL_2M) begin
				res_st   = ST_MAPPED;
				res_sz   = PG_2M;
				res_pa   = {rd[PA_W-1:21], va_q[20:0]};
				res_user = user_acc;
			end
		end else if (next_bad) begin
			res_st = ST_OUTSIDE;
		end else begin
			res_done = 1'b0;
		end
	end

	assign stat.done = res_done;

	// walk context and result register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			va_q   <= virt_addr;
			bad_q  <= root_bad;
			user_q <= 1'b1;
		end else if (cmd.walk_next) begin
			user_q <= user_acc;
		end
		if (cmd.load_out) begin
			status    <= res_st;
			phys_addr <= res_pa;
			pg_size   <= res_sz;
			user_ok   <= res_user;
		end
	end

endmodule

// ===== src/pgw_ctrl.sv =====
// Page walker controller: clear pass, item acceptance, level sequencing
// and the response valid flag.
// Depends on pgw_pkg.
module pgw_ctrl import pgw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      req_op,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_HOLD
	} state_t;

	state_t     state_q;
	logic [1:0] level_q;
	logic       rsp_valid_q;
	logic       out_free;
	logic       fin;
	logic       accept;

	// handshake and command decode
	always_comb begin
		out_free  = ~rsp_valid_q | rsp_ready;
		fin       = ((state_q == S_WALK) || (state_q == S_HOLD)) && stat.done;
		req_ready = (state_q == S_IDLE) || (fin && out_free);
		accept    = req_valid & req_ready;

		cmd.clear_step = (state_q == S_CLEAR);
		cmd.wr_item    = accept & (req_op == OP_WRITE);
		cmd.start      = accept & (req_op == OP_XLATE);
		cmd.walk_next  = (state_q == S_WALK) && !stat.done;
		cmd.load_out   = fin && out_free;
		cmd.level      = level_q;
	end

	assign rsp_valid = rsp_valid_q;

	// state, level counter and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			level_q     <= LVL_TOP;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q) inside
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= S_WALK;
						level_q <= LVL_TOP;
					end
				end
				S_WALK, S_HOLD: begin
					if (cmd.walk_next) begin
						level_q <= level_q - 2'd1;
					end else if (cmd.load_out) begin
						// a new translation may enter as this one leaves
						if (cmd.start) begin
							state_q <= S_WALK;
							level_q <= LVL_TOP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_HOLD;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// never overwrite a result still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("result register loaded while full");

	// the walk never steps past the leaf level
	a_leaf_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_next |-> (level_q != LVL_LEAF))
		else $error("walk stepped past leaf level");

	// every translation starts at the top level
	a_start_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (level_q == LVL_TOP && state_q == S_WALK))
		else $error("translation did not start at top level");

	// a held walk keeps its finished result until it is sent
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> stat.done)
		else $error("held walk lost its result");

	// no item is taken during the clear pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!cmd.wr_item && !cmd.start && !rsp_valid_q))
		else $error("item activity during clear pass");

endmodule

// ===== src/four_level_page_walker_unit.sv =====
// Four-level page walker: top level joining controller and datapath.
// Depends on pgw_pkg, pgw_ifs, pgw_ctrl, pgw_datapath.
//
// Usage:
//   req carries items: operation 0 writes entry_value at entry_index of the
//   table store (indexes at or above FRAMES*512 are dropped); operation 1
//   translates virt_addr starting at the root frame. rsp returns one result
//   per translation (status, phys_addr, pg_size, user_ok), none per write.
//   cfg_we/cfg_wdata set root_frame; write it only while the block is idle.
// Reset: root_frame clears to 0 and a clearing pass zeroes all FRAMES*512
//   store entries (8192 at the default), one entry per cycle; req.ready
//   stays low until it is done.
// Operation: a write is stored in the cycle it is accepted. A translation
//   does one dependent store read per level, then the result sits in the
//   output register; if the output is free, the next item is accepted in
//   the cycle the walk finishes, so a new translation can enter only as the
//   last one's result leaves, not while that one is still walking.
// Stall: if rsp is stalled, the walker still accepts and finishes the next
//   translation, then holds it (req.ready low) until the output frees.
module four_level_page_walker_unit import pgw_pkg::*; #(
	parameter int FRAMES = DEF_FRAMES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ROOT_W-1:0] cfg_wdata,
	pgw_req_if.sink           req,
	pgw_rsp_if.source         rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	pgw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_op   (req.operation),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pgw_datapath #(
		.FRAMES(FRAMES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.stat       (stat),
		.entry_index(req.entry_index),
		.entry_value(req.entry_value),
		.virt_addr  (req.virt_addr),
		.status     (rsp.status),
		.phys_addr  (rsp.phys_addr),
		.pg_size    (rsp.pg_size),
		.user_ok    (rsp.user_ok)
	);

endmodule
